[sv/atds_pkg.sv]
// shared widths, command and status codes for the alarm table due scan block
`timescale 1ns / 1ps

package atds_pkg;

  // field widths
  localparam int OPCODE_W = 3;
  localparam int TIME_W   = 32;
  localparam int ENTRY_W  = 5;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 2;
  localparam int ACTIVE_W = 5;

  // packed beat widths, padded to whole bytes
  localparam int IN_W  = 72;
  localparam int OUT_W = 32;

  // default table size
  localparam int TABLE_DEPTH_DEF = 16;

  // command codes
  localparam logic [OPCODE_W-1:0] OP_CHECK   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_DELETE  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CONSUME = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING   = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_VALID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STORE_READY = 1'b1;

endpackage

[sv/atds_mem.sv]
// alarm time and id storage, one write port and one registered read port
`timescale 1ns / 1ps

module atds_mem
  import atds_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int AW    = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [TIME_W-1:0] wtime_i,
  input  logic [ID_W-1:0]   wid_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [TIME_W-1:0] rtime_o,
  output logic [ID_W-1:0]   rid_o
);

  logic [TIME_W-1:0] tm_mem [DEPTH];
  logic [ID_W-1:0]   id_mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      tm_mem[waddr_i] <= wtime_i;
      id_mem[waddr_i] <= wid_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rtime_o <= tm_mem[raddr_i];
    rid_o   <= id_mem[raddr_i];
  end

endmodule

[sv/alarm_table_due_scan_core.sv]
// alarm table due scan: command sequencer over a shared table memory port
`timescale 1ns / 1ps
// clear, consume, rejected commands and check while pending go straight to the result beat
// check: scans table entries, stops when an alarm fires; add: compacts entries, then
// appends; delete: searches entries, then shifts the tail down
// a stalled result beat holds the next command
// one command at a time; the single read and write port of the table sets the pace
// rst_ni clears the entry count, done marks, pending alarm and config; next id is 1
// table contents are not cleared, entries above the count are never read

module alarm_table_due_scan_core
  import atds_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // opcode, now_time, alarm_time, entry_number (from bit 0 up)
  input  logic [IN_W-1:0]      s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // status, fired, alarm_id, active_count, pending_flag (from bit 0 up)
  output logic [OUT_W-1:0]     m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic                 cfg_data_i
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = (CW > ENTRY_W) ? CW : ENTRY_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK_RD, S_CHK_CMP, S_SQZ_RD, S_SQZ_WR, S_ADD_APP,
    S_DEL_FIND, S_DEL_RD, S_DEL_WR, S_DONE
  } state_e;

  state_e                  state_q;
  logic                    clock_valid_q, store_ready_q;
  logic [TIME_W-1:0]       now_q, when_q;
  logic [ENTRY_W-1:0]      num_q;
  logic [CW-1:0]           count_q, active_q, ptr_q, wptr_q, seen_q;
  logic [ID_W-1:0]         next_id_q, pend_id_q, res_id_q;
  logic                    pend_v_q, res_fired_q;
  logic [STATUS_W-1:0]     res_status_q;
  logic [TABLE_DEPTH-1:0]  done_q;
  logic                    m_valid_q;
  logic [OUT_W-1:0]        m_data_q;

  // input field split
  logic [OPCODE_W-1:0] in_op;
  logic [TIME_W-1:0]   in_now, in_when;
  logic [ENTRY_W-1:0]  in_num;
  assign in_op   = s_axis_tdata[OPCODE_W-1:0];
  assign in_now  = s_axis_tdata[OPCODE_W +: TIME_W];
  assign in_when = s_axis_tdata[OPCODE_W+TIME_W +: TIME_W];
  assign in_num  = s_axis_tdata[OPCODE_W+2*TIME_W +: ENTRY_W];

  // table memory
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [TIME_W-1:0] mem_wtime, rd_time;
  logic [ID_W-1:0]   mem_wid, rd_id;

  atds_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wtime_i (mem_wtime),
    .wid_i   (mem_wid),
    .raddr_i (ptr_q[AW-1:0]),
    .rtime_o (rd_time),
    .rid_o   (rd_id)
  );

  // shared helpers
  logic          ptr_done, src_live, due, out_free, seen_hit;
  logic [CW-1:0] ptr_inc, wptr_inc, seen_inc;
  assign ptr_done = done_q[ptr_q[AW-1:0]];
  assign src_live = (ptr_q < count_q);
  assign due      = (rd_time <= now_q);
  assign ptr_inc  = ptr_q + 1'b1;
  assign wptr_inc = wptr_q + 1'b1;
  assign seen_inc = seen_q + 1'b1;
  assign seen_hit = (NW'(seen_inc) == NW'(num_q));
  assign out_free = !m_valid_q || m_axis_tready;

  // memory write decode
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wptr_q[AW-1:0];
    mem_wtime = rd_time;
    mem_wid   = rd_id;
    unique case (state_q)
      S_SQZ_WR:  mem_we = !ptr_done;
      S_DEL_WR:  mem_we = 1'b1;
      S_ADD_APP: begin
        mem_we    = (wptr_q < DEPTH_C);
        mem_wtime = when_q;
        mem_wid   = next_id_q;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // sequencer, table state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      clock_valid_q <= 1'b0;
      store_ready_q <= 1'b0;
      count_q       <= '0;
      active_q      <= '0;
      ptr_q         <= '0;
      wptr_q        <= '0;
      seen_q        <= '0;
      next_id_q     <= ID_W'(1);
      pend_v_q      <= 1'b0;
      pend_id_q     <= '0;
      done_q        <= '0;
      res_status_q  <= ST_OK;
      res_fired_q   <= 1'b0;
      res_id_q      <= '0;
      m_valid_q     <= 1'b0;
      m_data_q      <= '0;
      now_q         <= '0;
      when_q        <= '0;
      num_q         <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CLOCK_VALID: clock_valid_q <= cfg_data_i;
          CFG_STORE_READY: store_ready_q <= cfg_data_i;
          default: ;
        endcase
      end

      // result beat taken, unless the completion state loads the next one
      if (m_valid_q && m_axis_tready && state_q != S_DONE) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            now_q        <= in_now;
            when_q       <= in_when;
            num_q        <= in_num;
            res_status_q <= ST_OK;
            res_fired_q  <= 1'b0;
            res_id_q     <= '0;
            ptr_q        <= '0;
            wptr_q       <= '0;
            seen_q       <= '0;
            state_q      <= S_DONE;
            unique case (in_op)
              OP_CHECK: begin
                if (!clock_valid_q) begin
                  res_status_q <= ST_NOT_READY;
                end else if (!pend_v_q) begin
                  state_q <= S_CHK_RD;
                end
              end
              OP_ADD: begin
                if (!store_ready_q || !clock_valid_q) begin
                  res_status_q <= ST_NOT_READY;
                end else begin
                  state_q <= S_SQZ_RD;
                end
              end
              OP_DELETE: begin
                if (in_num == '0 || NW'(in_num) > NW'(active_q)) begin
                  res_status_q <= ST_MISSING;
                end else begin
                  state_q <= S_DEL_FIND;
                end
              end
              OP_CLEAR: begin
                count_q   <= '0;
                active_q  <= '0;
                pend_v_q  <= 1'b0;
                pend_id_q <= '0;
              end
              OP_CONSUME: begin
                if (pend_v_q) begin
                  res_id_q  <= pend_id_q;
                  pend_v_q  <= 1'b0;
                  pend_id_q <= '0;
                end else begin
                  res_status_q <= ST_MISSING;
                end
              end
              default: ;
            endcase
          end
        end

        // due scan: read an entry, then compare it
        S_CHK_RD: begin
          state_q <= src_live ? S_CHK_CMP : S_DONE;
        end
        S_CHK_CMP: begin
          if (!ptr_done && due) begin
            done_q[ptr_q[AW-1:0]] <= 1'b1;
            pend_v_q    <= 1'b1;
            pend_id_q   <= rd_id;
            res_fired_q <= 1'b1;
            res_id_q    <= rd_id;
            active_q    <= active_q - 1'b1;
            state_q     <= S_DONE;
          end else begin
            ptr_q   <= ptr_inc;
            state_q <= S_CHK_RD;
          end
        end

        // compaction: copy live entries down to the write pointer
        S_SQZ_RD: begin
          state_q <= src_live ? S_SQZ_WR : S_ADD_APP;
        end
        S_SQZ_WR: begin
          if (!ptr_done) begin
            done_q[wptr_q[AW-1:0]] <= 1'b0;
            wptr_q <= wptr_inc;
          end
          ptr_q   <= ptr_inc;
          state_q <= S_SQZ_RD;
        end
        S_ADD_APP: begin
          if (wptr_q < DEPTH_C) begin
            done_q[wptr_q[AW-1:0]] <= 1'b0;
            count_q   <= wptr_inc;
            active_q  <= wptr_inc;
            res_id_q  <= next_id_q;
            next_id_q <= next_id_q + 1'b1;
          end else begin
            count_q      <= wptr_q;
            active_q     <= wptr_q;
            res_status_q <= ST_FULL;
          end
          state_q <= S_DONE;
        end

        // delete: find the k-th live entry, then shift the tail down
        S_DEL_FIND: begin
          ptr_q <= ptr_inc;
          if (!ptr_done) begin
            seen_q <= seen_inc;
            if (seen_hit) begin
              wptr_q  <= ptr_q;
              state_q <= S_DEL_RD;
            end
          end
        end
        S_DEL_RD: begin
          if (src_live) begin
            state_q <= S_DEL_WR;
          end else begin
            count_q  <= count_q - 1'b1;
            active_q <= active_q - 1'b1;
            state_q  <= S_DONE;
          end
        end
        S_DEL_WR: begin
          done_q[wptr_q[AW-1:0]] <= ptr_done;
          wptr_q  <= wptr_inc;
          ptr_q   <= ptr_inc;
          state_q <= S_DEL_RD;
        end

        // result beat into the output register
        S_DONE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {(OUT_W - STATUS_W - 1 - ID_W - ACTIVE_W - 1)'(0), pend_v_q,
                          ACTIVE_W'(active_q), res_id_q, res_fired_q, res_status_q};
            state_q   <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // live entries never outnumber stored entries
  a_active_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= count_q)
    else $error("active count above entry count");

  // entry count stays within the table
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("entry count beyond table depth");

  // a fired result always reports a pending alarm
  a_fired_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_data_q[STATUS_W] |-> m_data_q[STATUS_W+1+ID_W+ACTIVE_W])
    else $error("fired without pending alarm");

  // a new result beat only comes out of the completion state
  a_beat_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_DONE))
    else $error("result beat raised outside completion");

endmodule
